// ===== rtl/fmtt_pkg.sv =====
// Shared types and constants for the floor move travel time block.
package fmtt_pkg;

  localparam int FLOOR_W = 8;
  localparam int CFG_W   = 16;
  localparam int DIST_W  = 24;
  localparam int PROD_W  = 40;
  localparam int NUM_W   = 45;
  localparam int WORK_W  = 46;
  localparam int REM_W   = 25;
  localparam int ALU_W   = 27;
  localparam int ROOT_W  = 23;
  localparam int MS_W    = 32;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = 6;

  localparam int DIV_STEPS  = 45;
  localparam int SQRT_STEPS = 23;

  localparam logic [MS_W-1:0] MS_MAX = 32'hFFFF_FFFF;

  localparam int CRUISE_SCALE = 1000;
  localparam int ACCEL_SCALE  = 2000000;

  localparam logic [1:0] REG_TOP_FLOOR = 2'd0;
  localparam logic [1:0] REG_SPACING   = 2'd1;
  localparam logic [1:0] REG_SPEED     = 2'd2;
  localparam logic [1:0] REG_ACCEL     = 2'd3;

  localparam logic [FLOOR_W-1:0] TOP_FLOOR_RST = 8'd255;
  localparam logic [CFG_W-1:0]   SPACING_RST   = 16'd3000;
  localparam logic [CFG_W-1:0]   SPEED_RST     = 16'd2000;
  localparam logic [CFG_W-1:0]   ACCEL_RST     = 16'd1000;

  typedef struct packed {
    logic [FLOOR_W-1:0] top_floor;
    logic [CFG_W-1:0]   floor_spacing_mm;
    logic [CFG_W-1:0]   speed_limit;
    logic [CFG_W-1:0]   accel_limit;
  } cfg_t;

endpackage

// ===== rtl/fmtt_cfg.sv =====
// APB register file holding the move profile settings.
module fmtt_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fmtt_pkg::ADDR_W-1:0]   paddr,
  input  logic [fmtt_pkg::DATA_W-1:0]   pwdata,
  output logic [fmtt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output fmtt_pkg::cfg_t                cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.top_floor        <= fmtt_pkg::TOP_FLOOR_RST;
      cfg.floor_spacing_mm <= fmtt_pkg::SPACING_RST;
      cfg.speed_limit      <= fmtt_pkg::SPEED_RST;
      cfg.accel_limit      <= fmtt_pkg::ACCEL_RST;
    end else if (wr_en) begin
      case (reg_idx)
        fmtt_pkg::REG_TOP_FLOOR: cfg.top_floor        <= pwdata[7:0];
        fmtt_pkg::REG_SPACING:   cfg.floor_spacing_mm <= pwdata[15:0];
        fmtt_pkg::REG_SPEED:     cfg.speed_limit      <= pwdata[15:0];
        fmtt_pkg::REG_ACCEL:     cfg.accel_limit      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fmtt_pkg::REG_TOP_FLOOR: prdata = {24'd0, cfg.top_floor};
      fmtt_pkg::REG_SPACING:   prdata = {16'd0, cfg.floor_spacing_mm};
      fmtt_pkg::REG_SPEED:     prdata = {16'd0, cfg.speed_limit};
      fmtt_pkg::REG_ACCEL:     prdata = {16'd0, cfg.accel_limit};
      default:                 prdata = '0;
    endcase
  end

endmodule

// ===== rtl/fmtt_core.sv =====
// Move sequencer with a shared multiplier and a shared compare-subtract unit.
module fmtt_core (
  input  logic                          clk,
  input  logic                          rst,
  input  fmtt_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [fmtt_pkg::FLOOR_W-1:0]  floor_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fmtt_pkg::FLOOR_W-1:0]  arrived_floor,
  output logic [fmtt_pkg::MS_W-1:0]     travel_ms
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL_D  = 4'd1;
  localparam logic [3:0] ST_MUL_AD = 4'd2;
  localparam logic [3:0] ST_MUL_VV = 4'd3;
  localparam logic [3:0] ST_SEL    = 4'd4;
  localparam logic [3:0] ST_DIV    = 4'd5;
  localparam logic [3:0] ST_POST   = 4'd6;
  localparam logic [3:0] ST_SQRT   = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  logic [3:0]                       state;
  logic [fmtt_pkg::FLOOR_W-1:0]     present_floor;
  logic [fmtt_pkg::FLOOR_W-1:0]     floors;
  logic [fmtt_pkg::DIST_W-1:0]      dist_mm;
  logic [fmtt_pkg::PROD_W-1:0]      prod_ad;
  logic                             cruise;
  logic [fmtt_pkg::CFG_W-1:0]       divisor;
  logic [fmtt_pkg::WORK_W-1:0]      work;
  logic [fmtt_pkg::REM_W-1:0]       rem;
  logic [fmtt_pkg::ROOT_W-1:0]      root;
  logic [fmtt_pkg::CNT_W-1:0]       cnt;
  logic [fmtt_pkg::MS_W-1:0]        result;

  logic                             accept;
  logic [fmtt_pkg::FLOOR_W:0]       up_sum;
  logic [fmtt_pkg::FLOOR_W-1:0]     target;
  logic [fmtt_pkg::FLOOR_W-1:0]     move_floors;

  logic [fmtt_pkg::CFG_W-1:0]       mul_a;
  logic [fmtt_pkg::DIST_W-1:0]      mul_b;
  logic [fmtt_pkg::PROD_W-1:0]      mul_p;

  logic [fmtt_pkg::ALU_W-1:0]       alu_a;
  logic [fmtt_pkg::ALU_W-1:0]       alu_b;
  logic [fmtt_pkg::ALU_W:0]         alu_diff;
  logic                             alu_ge;

  logic [fmtt_pkg::NUM_W-1:0]       num_cruise;
  logic [fmtt_pkg::NUM_W-1:0]       num_accel;
  logic                             load_out;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign load_out = (state == ST_DONE) && (!out_valid || !out_stall);

  // clamped target floor
  always_comb begin
    up_sum = {1'b0, present_floor} + {1'b0, floor_count};
    if (opcode) begin
      target = (floor_count >= present_floor) ? '0 : present_floor - floor_count;
    end else if (up_sum > {1'b0, cfg.top_floor}) begin
      target = cfg.top_floor;
    end else begin
      target = up_sum[fmtt_pkg::FLOOR_W-1:0];
    end
    move_floors = (target >= present_floor) ? target - present_floor
                                            : present_floor - target;
  end

  // shared multiplier
  always_comb begin
    case (state)
      ST_MUL_D: begin
        mul_a = cfg.floor_spacing_mm;
        mul_b = {16'd0, floors};
      end
      ST_MUL_AD: begin
        mul_a = cfg.accel_limit;
        mul_b = dist_mm;
      end
      default: begin
        mul_a = cfg.speed_limit;
        mul_b = {8'd0, cfg.speed_limit};
      end
    endcase
    mul_p = {24'd0, mul_a} * {16'd0, mul_b};
  end

  // shared compare-subtract: restoring divide step or square-root digit step
  always_comb begin
    if (state == ST_SQRT) begin
      alu_a = {rem, work[45:44]};
      alu_b = {2'b00, root, 2'b01};
    end else begin
      alu_a = {10'd0, rem[15:0], work[44]};
      alu_b = {11'd0, divisor};
    end
    alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    alu_ge   = !alu_diff[fmtt_pkg::ALU_W];
  end

  assign num_cruise = fmtt_pkg::NUM_W'(dist_mm) * fmtt_pkg::NUM_W'(fmtt_pkg::CRUISE_SCALE);
  assign num_accel  = fmtt_pkg::NUM_W'(dist_mm) * fmtt_pkg::NUM_W'(fmtt_pkg::ACCEL_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      present_floor <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            present_floor <= target;
            state         <= ST_MUL_D;
          end
        end
        ST_MUL_D:  state <= ST_MUL_AD;
        ST_MUL_AD: state <= ST_MUL_VV;
        ST_MUL_VV: state <= ST_SEL;
        ST_SEL: begin
          if (dist_mm == '0) begin
            state <= ST_DONE;
          end else if (cruise && cfg.speed_limit == '0) begin
            state <= ST_DONE;
          end else if (!cruise && cfg.accel_limit == '0) begin
            state <= ST_DONE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == '0) state <= ST_POST;
        end
        ST_POST: state <= cruise ? ST_DONE : ST_SQRT;
        ST_SQRT: begin
          if (cnt == '0) state <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        floors <= move_floors;
      end
      ST_MUL_D:  dist_mm <= mul_p[fmtt_pkg::DIST_W-1:0];
      ST_MUL_AD: prod_ad <= mul_p;
      ST_MUL_VV: begin
        cruise <= (prod_ad > {7'd0, mul_p[31:0], 1'b0});
      end
      ST_SEL: begin
        rem <= '0;
        cnt <= fmtt_pkg::CNT_W'(fmtt_pkg::DIV_STEPS - 1);
        if (dist_mm == '0) begin
          result <= '0;
        end else begin
          result <= fmtt_pkg::MS_MAX;
        end
        if (cruise) begin
          divisor <= cfg.speed_limit;
          work    <= {1'b0, num_cruise};
        end else begin
          divisor <= cfg.accel_limit;
          work    <= {1'b0, num_accel};
        end
      end
      ST_DIV: begin
        rem  <= alu_ge ? alu_diff[fmtt_pkg::REM_W-1:0] : alu_a[fmtt_pkg::REM_W-1:0];
        work <= {1'b0, work[43:0], alu_ge};
        cnt  <= cnt - 1'b1;
      end
      ST_POST: begin
        rem  <= '0;
        root <= '0;
        cnt  <= fmtt_pkg::CNT_W'(fmtt_pkg::SQRT_STEPS - 1);
        if (work[44:32] != '0) begin
          result <= fmtt_pkg::MS_MAX;
        end else begin
          result <= work[31:0];
        end
      end
      ST_SQRT: begin
        rem  <= alu_ge ? alu_diff[fmtt_pkg::REM_W-1:0] : alu_a[fmtt_pkg::REM_W-1:0];
        root <= {root[fmtt_pkg::ROOT_W-2:0], alu_ge};
        work <= {work[43:0], 2'b00};
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          result <= {9'd0, root[fmtt_pkg::ROOT_W-2:0], alu_ge};
        end
      end
      ST_DONE: begin
        if (load_out) begin
          arrived_floor <= present_floor;
          travel_ms     <= result;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/floor_move_travel_time_top.sv =====
// Top level of the floor move travel time block.
//
// channel  direction  handshake          payload
// cfg      in         psel/penable/pwrite paddr, pwdata, prdata
// in       in         in_valid/in_stall   opcode, floor_count
// out      out        out_valid/out_stall arrived_floor, travel_ms
//
// The cruise branch uses the bit-serial divider (45 steps) and the square-root branch
// adds the root extractor (23 steps); the two share one compare-subtract unit, and
// a zero distance or limit skips both.
// in_stall is high from acceptance until the result is loaded into the output register.
// A result waits in the output register while out_stall is high; the next item may
// then be accepted. Reset clears the floor, the sequencer and the output valid.
module floor_move_travel_time_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fmtt_pkg::ADDR_W-1:0]   paddr,
  input  logic [fmtt_pkg::DATA_W-1:0]   pwdata,
  output logic [fmtt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [fmtt_pkg::FLOOR_W-1:0]  floor_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fmtt_pkg::FLOOR_W-1:0]  arrived_floor,
  output logic [fmtt_pkg::MS_W-1:0]     travel_ms
);

  fmtt_pkg::cfg_t cfg;

  fmtt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fmtt_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .floor_count   (floor_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .arrived_floor (arrived_floor),
    .travel_ms     (travel_ms)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sequencer not busy after item accepted");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in progress");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid set after reset");
`endif

endmodule
